/* rtl/gffs_pkg.sv */
package gffs_pkg;
  localparam int SymbolCount = 64;
  localparam int StoreDepth  = 256;
  localparam int SymW        = 6;
  localparam int AddrW       = $clog2(StoreDepth);
  localparam int FillW       = AddrW + 1;
  localparam int SetW        = 64;
  localparam int EpsBit      = 62;
  localparam int EndBit      = 63;
  localparam int PassLimit   = 100;
  localparam int PassW       = $clog2(PassLimit + 1);
  localparam int TermMax     = 62;

  localparam logic CfgTermCount  = 1'b0;
  localparam logic CfgStartSym   = 1'b1;

  typedef struct packed {
    logic [SymW-1:0] head;
    logic [SymW-1:0] sym;
    logic            empty;
    logic            last;
  } entry_t;

  typedef struct packed {
    logic [SymW-1:0] production_head;
    logic [SymW-1:0] body_symbol;
    logic            body_empty;
    logic            production_end;
    logic            grammar_end;
  } item_t;

  typedef struct packed {
    logic [SymW-1:0] symbol_id;
    logic [SetW-1:0] first_set;
    logic [SetW-1:0] follow_set;
    logic            store_overflow;
    logic            last_symbol;
  } result_t;
endpackage

/* rtl/gffs_if.sv */
interface gffs_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/gffs_store.sv */
module gffs_store
  import gffs_pkg::*;
(
  input  logic                 clk,
  input  logic                 we,
  input  logic [AddrW-1:0]     waddr,
  input  entry_t               wdata,
  input  logic [AddrW-1:0]     raddr,
  output entry_t               rdata
);
  entry_t mem [StoreDepth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/gffs_setram.sv */
module gffs_setram
  import gffs_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [SymW-1:0]  waddr,
  input  logic [SetW-1:0]  wdata,
  input  logic [SymW-1:0]  raddr,
  output logic [SetW-1:0]  rdata
);
  logic [SetW-1:0] mem [SymbolCount];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/grammar_first_follow_sets_unit.sv */
// channel | dir | payload
// item    | in  | production_head, body_symbol, body_empty, production_end, grammar_end
// result  | out | symbol_id, first_set, follow_set, store_overflow, last_symbol
// Load items are stored as they are accepted until the store fills. A grammar_end
// item first clears both set memories. A FIRST pass reads every stored entry and
// updates the FIRST set of each production head; a FOLLOW pass scans each entry,
// each nonterminal body entry rescanning its tail up to a non-nullable symbol,
// and updates FOLLOW sets. Then 64 results follow, one per symbol.
// Input is not ready from grammar_end until the last result is taken.
// Output stalls hold the result register; rst is synchronous.
module grammar_first_follow_sets_unit
  import gffs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  gffs_if.sink            item,
  gffs_if.source          result,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [SymW-1:0] cfg_data
);
  localparam logic [3:0] S_LOAD = 4'd0, S_CLR = 4'd1, S_PSTART = 4'd2,
    S_SRD = 4'd3, S_SSYM = 4'd4, S_SUSE = 4'd5, S_FWA = 4'd6, S_FWB = 4'd7,
    S_OWA = 4'd8, S_OWB = 4'd9, S_OWC = 4'd10, S_PNEXT = 4'd11,
    S_ORD = 4'd12, S_OWAIT = 4'd13, S_OUT = 4'd14;
  localparam logic [SetW-1:0] EpsMask = SetW'(1) << EpsBit;

  logic [3:0] state;
  logic [SymW-1:0] term_cnt, start_sym;
  logic [FillW-1:0] fill;
  logic ovf, phase_follow, changed, live, tgt_last;
  logic [PassW-1:0] passes;
  logic [AddrW-1:0] p, j, k;
  logic [SymW-1:0] h, b, sid;
  logic [SetW-1:0] acc, fol_h;

  entry_t st_w, st_r;
  logic [AddrW-1:0] st_ra;
  logic fi_we, fo_we;
  logic [SymW-1:0] fi_wa, fo_wa, fi_ra, fo_ra;
  logic [SetW-1:0] fi_wd, fo_wd, fi_rd, fo_rd;

  gffs_store u_store (.clk, .we(item.valid && item.ready && !fill[AddrW]),
    .waddr(fill[AddrW-1:0]), .wdata(st_w), .raddr(st_ra), .rdata(st_r));
  gffs_setram u_first (.clk, .we(fi_we), .waddr(fi_wa), .wdata(fi_wd),
    .raddr(fi_ra), .rdata(fi_rd));
  gffs_setram u_follow (.clk, .we(fo_we), .waddr(fo_wa), .wdata(fo_wd),
    .raddr(fo_ra), .rdata(fo_rd));

  logic [SymW-1:0] tl;
  assign tl = (term_cnt > SymW'(TermMax)) ? SymW'(TermMax) : term_cnt;
  function automatic logic is_nt(input logic [SymW-1:0] s, input logic [SymW-1:0] t);
    return (s >= t) && (int'(s) < SymbolCount);
  endfunction

  assign st_w = '{head: item.data.production_head, sym: item.data.body_symbol,
    empty: item.data.body_empty,
    last: item.data.production_end | item.data.grammar_end};
  assign item.ready = (state == S_LOAD) && !rst;

  logic ent_last;
  assign ent_last = st_r.last || ({1'b0, k} + FillW'(1) >= fill);

  // scan pointer for the store read
  assign st_ra = k;

  // first_of of the current scanned symbol
  logic [SetW-1:0] fsym;
  assign fsym = is_nt(st_r.sym, tl) ? fi_rd : (SetW'(1) << st_r.sym);

  logic null_now;
  logic [SetW-1:0] acc_scan, fi_upd, fo_upd;
  assign null_now = st_r.empty || fsym[EpsBit];
  assign acc_scan = acc | ((live && !st_r.empty) ? (fsym & ~EpsMask) : '0) |
                    ((live && null_now && ent_last) ? EpsMask : '0);
  assign fi_upd = fi_rd | acc;
  assign fo_upd = fo_rd | (acc & ~EpsMask) | (acc[EpsBit] ? fol_h : '0);

  always_comb begin
    fi_we = 1'b0; fo_we = 1'b0;
    fi_wa = h; fo_wa = b;
    fi_wd = '0; fo_wd = '0;
    fi_ra = st_r.sym; fo_ra = h;
    if (state == S_CLR) begin
      fi_we = 1'b1; fo_we = 1'b1; fi_wa = sid; fo_wa = sid;
      if (sid == start_sym && is_nt(start_sym, tl)) fo_wd[EndBit] = 1'b1;
    end
    if (state == S_FWA) fi_ra = h;
    if (state == S_FWB && is_nt(h, tl)) begin
      fi_we = 1'b1; fi_wd = fi_upd;
    end
    if (state == S_OWB) fo_ra = b;
    if (state == S_OWC) begin
      fo_we = 1'b1; fo_wd = fo_upd;
    end
    if (state == S_ORD) begin fi_ra = sid; fo_ra = sid; end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; fill <= '0; ovf <= 1'b0; term_cnt <= SymW'(32);
      start_sym <= SymW'(32); result.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgTermCount) term_cnt <= cfg_data;
        else start_sym <= cfg_data;
      end
      unique case (state)
        S_LOAD: if (item.valid) begin
          if (fill[AddrW]) ovf <= 1'b1; else fill <= fill + FillW'(1);
          if (item.data.grammar_end) begin state <= S_CLR; sid <= '0; end
        end
        S_CLR: begin
          sid <= sid + SymW'(1);
          if (sid == SymW'(SymbolCount-1)) begin
            phase_follow <= 1'b0; passes <= '0; p <= '0;
            changed <= 1'b0; state <= S_PSTART;
          end
        end
        S_PSTART: begin
          k <= p; j <= p; state <= S_SRD;
        end
        S_SRD: state <= S_SSYM;
        S_SSYM: begin
          if (k == p) begin
            h <= st_r.head; acc <= '0; live <= 1'b1;
          end
          state <= S_SUSE;
        end
        // FIRST: k walks the production. FOLLOW: j is the target, k scans its tail.
        S_SUSE: begin
          if (!phase_follow) begin
            acc <= acc_scan; live <= live && null_now;
            if (ent_last) state <= S_FWA;
            else begin k <= k + AddrW'(1); state <= S_SRD; end
          end else if (k == j) begin
            tgt_last <= ent_last;
            if (st_r.empty || !is_nt(st_r.sym, tl) || !is_nt(h, tl)) begin
              if (ent_last) state <= S_PNEXT;
              else begin
                j <= j + AddrW'(1); k <= k + AddrW'(1); state <= S_SRD;
              end
            end else begin
              b <= st_r.sym; live <= 1'b1;
              if (ent_last) begin
                acc <= EpsMask; state <= S_OWA;
              end else begin
                acc <= '0; k <= k + AddrW'(1); state <= S_SRD;
              end
            end
          end else begin
            acc <= acc_scan;
            if (!null_now || ent_last) state <= S_OWA;
            else begin k <= k + AddrW'(1); state <= S_SRD; end
          end
        end
        S_FWA: state <= S_FWB;
        S_FWB: begin
          if (is_nt(h, tl) && fi_upd != fi_rd) changed <= 1'b1;
          state <= S_PNEXT;
        end
        S_OWA: state <= S_OWB;
        S_OWB: begin
          fol_h <= fo_rd; state <= S_OWC;
        end
        S_OWC: begin
          if (fo_upd != fo_rd) changed <= 1'b1;
          if (tgt_last) state <= S_PNEXT;
          else begin
            j <= j + AddrW'(1); k <= j + AddrW'(1); state <= S_SRD;
          end
        end
        S_PNEXT: begin
          // k holds the last entry of the finished production
          if ({1'b0, k} + FillW'(1) < fill) begin
            p <= k + AddrW'(1); state <= S_PSTART;
          end else if (phase_follow && !changed) begin
            sid <= '0; state <= S_ORD;
          end else begin
            p <= '0; changed <= 1'b0; state <= S_PSTART;
            if (!phase_follow) begin
              passes <= passes + PassW'(1);
              if (!(changed && passes + PassW'(1) < PassW'(PassLimit)))
                phase_follow <= 1'b1;
            end
          end
        end
        S_ORD: state <= S_OWAIT;
        S_OWAIT: begin
          result.valid <= 1'b1;
          result.data.symbol_id <= sid;
          result.data.first_set <= is_nt(sid, tl) ? fi_rd : (SetW'(1) << sid);
          result.data.follow_set <= is_nt(sid, tl) ? fo_rd : '0;
          result.data.store_overflow <= ovf;
          result.data.last_symbol <= (sid == SymW'(SymbolCount-1));
          state <= S_OUT;
        end
        S_OUT: if (result.ready) begin
          result.valid <= 1'b0;
          if (sid == SymW'(SymbolCount-1)) begin
            fill <= '0; ovf <= 1'b0; state <= S_LOAD;
          end else begin
            sid <= sid + SymW'(1); state <= S_ORD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

/* rtl/gffs_checker.sv */
module gffs_checker
  import gffs_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [SymW-1:0] out_id,
  input logic out_last
);
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input accepted while result pending");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_id == SymW'(SymbolCount-1))))
    else $error("last flag mismatch");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_id))
    else $error("stalled result changed");
endmodule

bind grammar_first_follow_sets_unit gffs_checker u_chk (.clk, .rst,
  .in_valid(item.valid), .in_ready(item.ready), .out_valid(result.valid),
  .out_ready(result.ready), .out_id(result.data.symbol_id),
  .out_last(result.data.last_symbol));
